### sv/log_timestamp_parser_unit_assert.svh
// Assertion macros shared by the timestamp parser modules.
`ifndef LOG_TIMESTAMP_PARSER_UNIT_ASSERT_SVH
`define LOG_TIMESTAMP_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LTP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timestamp parser assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timestamp parser assertion failed");

`endif

### sv/ltp_pkg.sv
// Types, constants and token functions of the timestamp parser.
`timescale 1ns / 1ps
package ltp_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [8:0] POS_LIMIT = 9'd256;

    localparam logic [2:0] TOK_DAY    = 3'd0;
    localparam logic [2:0] TOK_MONTH  = 3'd1;
    localparam logic [2:0] TOK_YEAR   = 3'd2;
    localparam logic [2:0] TOK_HOUR   = 3'd3;
    localparam logic [2:0] TOK_MINUTE = 3'd4;
    localparam logic [2:0] TOK_SECOND = 3'd5;
    localparam logic [2:0] TOK_DONE   = 3'd6;

    localparam logic [2:0] MONTH_LEN  = 3'd3;
    localparam logic [2:0] MONTH_OVER = 3'd4;

    localparam int NUM_MONTHS = 12;
    localparam logic [23:0] MONTH_NAMES [NUM_MONTHS] = '{
        "Jan", "Feb", "Mar", "Apr", "May", "Jun",
        "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
    };

    typedef struct packed {
        logic [7:0] character;
        logic       is_sep;
        logic       is_digit;
        logic [3:0] digit;
        logic       skip;
        logic       last;
    } char_class_t;

    typedef struct packed {
        logic [2:0]      tok;
        logic [15:0]     nv;
        logic            de;
        logic [2:0][7:0] ml;
        logic [2:0]      mlc;
        logic [7:0]      day;
        logic [3:0]      month;
        logic [15:0]     year;
        logic [7:0]      hour;
        logic [7:0]      minute;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } record_t;

    function automatic logic [3:0] month_code(input logic [2:0] mlc,
                                              input logic [2:0][7:0] ml);
        logic [3:0]  code;
        logic [23:0] word;
        code = 4'd0;
        word = {ml[0], ml[1], ml[2]};
        if (mlc == MONTH_LEN) begin
            for (int m = NUM_MONTHS - 1; m >= 0; m--) begin
                if (word == MONTH_NAMES[m]) begin
                    code = 4'(m + 1);
                end
            end
        end
        return code;
    endfunction

    function automatic parse_state_t close_token(input parse_state_t s);
        parse_state_t r;
        r = s;
        case (s.tok)
            TOK_DAY:    r.day    = s.nv[7:0];
            TOK_MONTH:  r.month  = month_code(s.mlc, s.ml);
            TOK_YEAR:   r.year   = s.nv;
            TOK_HOUR:   r.hour   = s.nv[7:0];
            TOK_MINUTE: r.minute = s.nv[7:0];
            TOK_SECOND: r.tok    = TOK_DONE;
            default:    r = s;
        endcase
        if (s.tok < TOK_SECOND) begin
            r.tok = s.tok + 3'd1;
            r.nv  = 16'd0;
            r.de  = 1'b0;
            r.mlc = 3'd0;
            r.ml  = '0;
        end
        return r;
    endfunction

endpackage

### sv/ltp_char_if.sv
// Character request channel.
`timescale 1ns / 1ps
interface ltp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

### sv/ltp_rec_if.sv
// Timestamp record request channel.
`timescale 1ns / 1ps
interface ltp_rec_if;
    logic        valid;
    logic        ready;
    logic [7:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;

    modport source (output valid, output day, output month, output year,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input day, input month, input year,
                    input hour, input minute, input second, output ready);
endinterface

### sv/ltp_front.sv
// Front end: accept characters, track line position, classify.
`timescale 1ns / 1ps
module ltp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    ltp_char_if.sink             chars,
    input  logic                 full,
    output logic                 push,
    output ltp_pkg::char_class_t cls
);
    import ltp_pkg::*;

    logic [8:0] pos_reg;
    logic [8:0] pos_next;

    assign chars.ready = !full;
    assign push        = chars.valid && !full;

    always_comb
    begin
        cls.character = chars.character;
        cls.is_sep    = (chars.character == CH_SLASH) || (chars.character == CH_COLON)
                        || (chars.character == CH_SPACE);
        cls.is_digit  = (chars.character >= CH_ZERO) && (chars.character <= CH_NINE);
        cls.digit     = 4'(chars.character - CH_ZERO);
        cls.skip      = (pos_reg == POS_LIMIT);
        cls.last      = chars.last;
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (push) begin
            if (chars.last) begin
                pos_next = 9'd0;
            end else if (pos_reg != POS_LIMIT) begin
                pos_next = pos_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= 9'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end
endmodule

### sv/ltp_queue.sv
// Short queue of classified characters between front and back end.
`timescale 1ns / 1ps
module ltp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ltp_pkg::char_class_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output ltp_pkg::char_class_t head
);
    import ltp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    char_class_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`include "log_timestamp_parser_unit_assert.svh"
    `LTP_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_FULL)
    `LTP_ASSERT_IMPLY(a_no_pop_empty, pop, head_valid)
    `LTP_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `LTP_ASSERT_IMPLY(a_ptr_gap, 1'b1,
        (count_reg == CNT_FULL) || (count_reg == '0) ? (wr_ptr_reg == rd_ptr_reg)
                                                     : (wr_ptr_reg != rd_ptr_reg))
endmodule

### sv/ltp_back.sv
// Back end: token parser state and record output register.
`timescale 1ns / 1ps
module ltp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  ltp_pkg::char_class_t head,
    output logic                 pop,
    ltp_rec_if.source            records
);
    import ltp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t taken;
    parse_state_t closed;
    record_t      rec_reg;
    record_t      rec_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [19:0]  acc;

    assign pop = head_valid && (!head.last || !out_valid_reg || records.ready);

    assign records.valid  = out_valid_reg;
    assign records.day    = rec_reg.day;
    assign records.month  = rec_reg.month;
    assign records.year   = rec_reg.year;
    assign records.hour   = rec_reg.hour;
    assign records.minute = rec_reg.minute;
    assign records.second = rec_reg.second;

    always_comb
    begin
        acc   = ({4'd0, state_reg.nv} << 3) + ({4'd0, state_reg.nv} << 1)
                + {16'd0, head.digit};
        taken = state_reg;
        if (!head.skip && state_reg.tok < TOK_DONE) begin
            if (head.is_sep) begin
                taken = close_token(state_reg);
            end else if (state_reg.tok == TOK_MONTH) begin
                if (state_reg.mlc < MONTH_LEN) begin
                    taken.ml[state_reg.mlc[1:0]] = head.character;
                end
                if (state_reg.mlc < MONTH_OVER) begin
                    taken.mlc = state_reg.mlc + 3'd1;
                end
            end else if (!state_reg.de) begin
                if (head.is_digit) begin
                    taken.nv = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
                end else begin
                    taken.de = 1'b1;
                end
            end
        end
        closed = close_token(taken);
    end

    always_comb
    begin
        state_next     = state_reg;
        rec_next       = rec_reg;
        out_valid_next = out_valid_reg && !records.ready;
        if (pop) begin
            if (head.last) begin
                state_next      = '0;
                out_valid_next  = 1'b1;
                rec_next.day    = closed.day;
                rec_next.month  = closed.month;
                rec_next.year   = closed.year;
                rec_next.hour   = closed.hour;
                rec_next.minute = closed.minute;
                rec_next.second = (closed.tok == TOK_DONE) ? closed.nv[7:0] : 8'd0;
            end else begin
                state_next = taken;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`include "log_timestamp_parser_unit_assert.svh"
    `LTP_ASSERT_IMPLY(a_tok_bound, 1'b1, state_reg.tok <= TOK_DONE)
    `LTP_ASSERT_IMPLY(a_mlc_bound, 1'b1, state_reg.mlc <= MONTH_OVER)
    `LTP_ASSERT_IMPLY(a_no_ended_month, state_reg.tok == TOK_MONTH, !state_reg.de)
    `LTP_ASSERT_NEXT(a_line_clears, pop && head.last,
        out_valid_reg && state_reg.tok == TOK_DAY && state_reg.nv == 16'd0)
endmodule

### sv/log_timestamp_parser_unit.sv
// Top level of the timestamp line parser.
//
// channel  | dir | request contents
// ---------+-----+------------------------------------------------
// chars    | in  | character[7:0], last
// records  | out | day[7:0], month[3:0], year[15:0], hour, minute, second
//
// One character per cycle sustained while no stalled record holds the back end; the token state update
// in the back end (multiply-by-ten accumulate and month compare) works on the character at the queue head.
// A record appears on records in the cycle after the back end takes the last character.
// Reset clears the line position, the queue pointers, the token state and the
// record valid flag. A stalled record holds the back end only when the next
// line end arrives; characters keep filling the queue meanwhile.
`timescale 1ns / 1ps
module log_timestamp_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    ltp_char_if.sink    chars,
    ltp_rec_if.source   records
);
    import ltp_pkg::*;

    char_class_t push_data;
    char_class_t head;
    logic        push;
    logic        full;
    logic        pop;
    logic        head_valid;

    ltp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .full  (full),
        .push  (push),
        .cls   (push_data)
    );

    ltp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    ltp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .records    (records)
    );
endmodule

### dv/log_timestamp_parser_unit_tb.sv
// Self-checking testbench for the timestamp line parser: directed lines, then random lines.
`timescale 1ns / 1ps
module log_timestamp_parser_unit_tb;
    import ltp_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        record_t    rec;
    } char_req_t;

    typedef struct {
        string      head;
        int         pad_len;
        logic [7:0] pad_char;
        string      tail;
        bit         typed;
        record_t    rec;
    } line_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ltp_char_if chars();
    ltp_rec_if  records();

    log_timestamp_parser_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .records (records)
    );

    string      month_tbl [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                                   "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
    logic [7:0] sep_tbl [3]    = '{CH_SLASH, CH_COLON, CH_SPACE};

    char_req_t  char_stream [$];
    logic [7:0] line_bytes [$];
    line_row_t  directed_rows [$];
    record_t    expected_records [$];

    int line_count;
    int directed_len;
    int accepted;
    int compared;
    int faults;
    int load_phase;

    logic [2:0]  tok_idx;
    logic [8:0]  line_pos;
    logic [15:0] num_acc;
    logic        num_stopped;
    logic [7:0]  mon_chars [3];
    logic [2:0]  mon_count;
    logic [7:0]  day_h;
    logic [3:0]  mon_h;
    logic [15:0] year_h;
    logic [7:0]  hour_h;
    logic [7:0]  min_h;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function void clear_parse();
        tok_idx     = TOK_DAY;
        line_pos    = '0;
        num_acc     = '0;
        num_stopped = 1'b0;
        mon_chars   = '{8'd0, 8'd0, 8'd0};
        mon_count   = '0;
        day_h       = '0;
        mon_h       = '0;
        year_h      = '0;
        hour_h      = '0;
        min_h       = '0;
    endfunction

    function logic [3:0] month_of_letters();
        logic [3:0] code;
        code = 4'd0;
        if (mon_count == 3'd3)
        begin
            for (int m = 0; m < 12; m++)
            begin
                if (mon_chars[0] == month_tbl[m][0] && mon_chars[1] == month_tbl[m][1] &&
                    mon_chars[2] == month_tbl[m][2])
                begin
                    code = 4'(m + 1);
                end
            end
        end
        return code;
    endfunction

    function void close_field();
        case (tok_idx)
            TOK_DAY:    day_h   = num_acc[7:0];
            TOK_MONTH:  mon_h   = month_of_letters();
            TOK_YEAR:   year_h  = num_acc;
            TOK_HOUR:   hour_h  = num_acc[7:0];
            TOK_MINUTE: min_h   = num_acc[7:0];
            TOK_SECOND: tok_idx = TOK_DONE;
            default: ;
        endcase
        if (tok_idx < TOK_SECOND)
        begin
            tok_idx     = tok_idx + 3'd1;
            num_acc     = '0;
            num_stopped = 1'b0;
            mon_count   = '0;
            mon_chars   = '{8'd0, 8'd0, 8'd0};
        end
    endfunction

    function void parse_char(input logic [7:0] ch, input logic fin,
                             output record_t rec, output bit fired);
        int unsigned wide;
        rec   = '0;
        fired = 1'b0;
        if (line_pos < POS_LIMIT)
        begin
            if (tok_idx < TOK_DONE)
            begin
                if (ch == CH_SLASH || ch == CH_COLON || ch == CH_SPACE)
                begin
                    close_field();
                end
                else if (tok_idx == TOK_MONTH)
                begin
                    if (mon_count < 3'd3)
                    begin
                        mon_chars[mon_count[1:0]] = ch;
                    end
                    if (mon_count < 3'd4)
                    begin
                        mon_count = mon_count + 3'd1;
                    end
                end
                else if (!num_stopped)
                begin
                    if (ch >= CH_ZERO && ch <= CH_NINE)
                    begin
                        wide    = 32'(num_acc) * 10 + 32'(ch - CH_ZERO);
                        num_acc = (wide > 32'd65535) ? 16'hFFFF : 16'(wide);
                    end
                    else
                    begin
                        num_stopped = 1'b1;
                    end
                end
            end
            line_pos = line_pos + 9'd1;
        end
        if (fin)
        begin
            close_field();
            rec.day    = day_h;
            rec.month  = mon_h;
            rec.year   = year_h;
            rec.hour   = hour_h;
            rec.minute = min_h;
            rec.second = (tok_idx >= TOK_DONE) ? num_acc[7:0] : 8'd0;
            fired      = 1'b1;
            clear_parse();
        end
    endfunction

    task automatic flush_line(input bit typed, input record_t rec);
        char_req_t req;
        for (int i = 0; i < line_bytes.size(); i++)
        begin
            req.ch    = line_bytes[i];
            req.fin   = (i == line_bytes.size() - 1);
            req.typed = typed;
            req.rec   = rec;
            char_stream.push_back(req);
        end
        line_count++;
    endtask

    task automatic put_number(input int min_d, input int max_d);
        int n;
        n = $urandom_range(max_d, min_d);
        if ($urandom_range(19) == 0)
        begin
            n = $urandom_range(6, 1);
        end
        repeat (n) line_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic put_sep(input logic [7:0] canon);
        if ($urandom_range(9) == 0)
        begin
            line_bytes.push_back(sep_tbl[$urandom_range(2)]);
        end
        else
        begin
            line_bytes.push_back(canon);
        end
        if ($urandom_range(29) == 0)
        begin
            line_bytes.push_back(canon);
        end
    endtask

    task automatic add_random_line();
        int    kind;
        int    n;
        int    pick;
        string mn;
        line_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            put_number(1, 2);
            put_sep(CH_SLASH);
            mn   = month_tbl[$urandom_range(11)];
            pick = $urandom_range(19);
            line_bytes.push_back((pick == 0) ? (mn[0] ^ 8'h20) : mn[0]);
            line_bytes.push_back(mn[1]);
            if (pick != 1)
            begin
                line_bytes.push_back(mn[2]);
            end
            if (pick == 2)
            begin
                line_bytes.push_back(8'($urandom_range(255)));
            end
            put_sep(CH_SLASH);
            put_number(4, 4);
            put_sep(CH_COLON);
            put_number(1, 2);
            put_sep(CH_COLON);
            put_number(1, 2);
            put_sep(CH_COLON);
            put_number(1, 3);
            if ($urandom_range(9) == 0)
            begin
                put_sep(CH_SPACE);
                put_number(1, 3);
            end
            if (kind >= 65)
            begin
                if ($urandom_range(1) == 0)
                begin
                    n = $urandom_range(line_bytes.size() - 1, 1);
                    while (line_bytes.size() > n) void'(line_bytes.pop_back());
                end
                else
                begin
                    repeat ($urandom_range(2, 1))
                        line_bytes[$urandom_range(line_bytes.size() - 1)] =
                            8'($urandom_range(255));
                end
            end
        end
        else if (kind < 98)
        begin
            n = $urandom_range(30, 1);
            repeat (n)
            begin
                case ($urandom_range(3))
                    0:       line_bytes.push_back(8'($urandom_range(255)));
                    1:       line_bytes.push_back(sep_tbl[$urandom_range(2)]);
                    default: line_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
                endcase
            end
        end
        else
        begin
            n = $urandom_range(300, 250);
            repeat (n)
            begin
                if ($urandom_range(7) == 0)
                begin
                    line_bytes.push_back(sep_tbl[$urandom_range(2)]);
                end
                else
                begin
                    line_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
                end
            end
        end
        flush_line(1'b0, '0);
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            faults++;
        end
    endtask

    always @(posedge clk)
    begin
        record_t predicted;
        bit      fired;
        if (rst_n)
        begin
            if (chars.valid && chars.ready)
            begin
                parse_char(chars.character, chars.last, predicted, fired);
                if (fired)
                begin
                    expected_records.push_back(char_stream[accepted].typed ?
                                               char_stream[accepted].rec : predicted);
                end
                accepted++;
            end
            if (records.valid && records.ready)
            begin
                if (expected_records.size() == 0)
                begin
                    $error("record with no line end pending");
                    faults++;
                end
                else
                begin
                    predicted = expected_records.pop_front();
                    check_field("day",    predicted.day,    records.day);
                    check_field("month",  predicted.month,  records.month);
                    check_field("year",   predicted.year,   records.year);
                    check_field("hour",   predicted.hour,   records.hour);
                    check_field("minute", predicted.minute, records.minute);
                    check_field("second", predicted.second, records.second);
                    compared++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (load_phase == 2)
        begin
            records.ready <= ($urandom_range(99) >= 53);
        end
        else if (load_phase == 3)
        begin
            records.ready <= ($urandom_range(99) >= 34);
        end
        else
        begin
            records.ready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("log_timestamp_parser_unit_tb failed");
        $finish;
    end

    initial
    begin
        int total;
        int sent;
        int ph;
        int guard;
        bit gap;
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.character = 8'd0;
        chars.last      = 1'b0;
        load_phase      = 0;
        line_count      = 0;
        accepted        = 0;
        compared        = 0;
        faults          = 0;
        clear_parse();

        directed_rows.push_back('{"10/Oct/2023:13:55:36", 0, 8'd0, "", 1'b1,
                                  {8'd10, 4'd10, 16'd2023, 8'd13, 8'd55, 8'd36}});
        directed_rows.push_back('{"A", 0, 8'd0, "", 1'b1, '0});
        directed_rows.push_back('{"/", 0, 8'd0, "", 1'b1, '0});
        directed_rows.push_back('{"99999/Jan/99999:300:256:999", 0, 8'd0, "", 1'b1,
                                  {8'd255, 4'd1, 16'd65535, 8'd44, 8'd0, 8'd231}});
        directed_rows.push_back('{"1/Dec/0:0:0:59/7/8", 0, 8'd0, "", 1'b1,
                                  {8'd1, 4'd12, 16'd0, 8'd0, 8'd0, 8'd59}});
        directed_rows.push_back('{"12a3/jan/2000", 0, 8'd0, "", 1'b1,
                                  {8'd12, 4'd0, 16'd2000, 8'd0, 8'd0, 8'd0}});
        directed_rows.push_back('{"5/Janu/1:2:3:", 0, 8'd0, "", 1'b1,
                                  {8'd5, 4'd0, 16'd1, 8'd2, 8'd3, 8'd0}});
        directed_rows.push_back('{"1/Ja/2", 0, 8'd0, "", 1'b1,
                                  {8'd1, 4'd0, 16'd2, 8'd0, 8'd0, 8'd0}});
        directed_rows.push_back('{"31 Aug 1970 23 59 59", 0, 8'd0, "", 1'b1,
                                  {8'd31, 4'd8, 16'd1970, 8'd23, 8'd59, 8'd59}});
        directed_rows.push_back('{"8//:: ", 0, 8'd0, "", 1'b1,
                                  {8'd8, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0}});
        directed_rows.push_back('{"", 256, CH_ZERO, "5/Apr/6", 1'b1, '0});
        directed_rows.push_back('{"", 255, CH_ZERO, "7/May", 1'b1,
                                  {8'd7, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0}});
        directed_rows.push_back('{"", 3, 8'hFF, "/Nov", 1'b1,
                                  {8'd0, 4'd11, 16'd0, 8'd0, 8'd0, 8'd0}});
        directed_rows.push_back('{"", 4, 8'h00, "", 1'b1, '0});
        directed_rows.push_back('{"00065535/Jun/65536", 0, 8'd0, "", 1'b1,
                                  {8'd255, 4'd6, 16'd65535, 8'd0, 8'd0, 8'd0}});
        directed_rows.push_back('{"29/Feb/2024:00:00:00 extra", 0, 8'd0, "", 1'b0, '0});
        directed_rows.push_back('{"x9/Sep/ 8:", 0, 8'd0, "", 1'b0, '0});
        directed_rows.push_back('{"3/Jul/1", 2, CH_SPACE, "4:5", 1'b0, '0});

        foreach (directed_rows[r])
        begin
            line_bytes.delete();
            for (int i = 0; i < directed_rows[r].head.len(); i++)
                line_bytes.push_back(directed_rows[r].head[i]);
            repeat (directed_rows[r].pad_len) line_bytes.push_back(directed_rows[r].pad_char);
            for (int i = 0; i < directed_rows[r].tail.len(); i++)
                line_bytes.push_back(directed_rows[r].tail[i]);
            flush_line(directed_rows[r].typed, directed_rows[r].rec);
        end
        directed_len = char_stream.size();
        while (char_stream.size() < 1500) add_random_line();
        total = char_stream.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        sent = 0;
        while (sent < total)
        begin
            @(posedge clk);
            if (chars.valid && chars.ready)
            begin
                sent++;
            end
            ph = (sent / 100) % 4;
            load_phase <= ph;
            if (!(chars.valid && !chars.ready))
            begin
                gap = (ph == 1) ? ($urandom_range(99) < 53) :
                      (ph == 3) ? ($urandom_range(99) < 34) : 1'b0;
                if (sent < total && !gap)
                begin
                    chars.valid     <= 1'b1;
                    chars.character <= char_stream[sent].ch;
                    chars.last      <= char_stream[sent].fin;
                end
                else
                begin
                    chars.valid <= 1'b0;
                end
            end
        end

        guard = 0;
        while (expected_records.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (expected_records.size() != 0)
        begin
            $error("%0d records never arrived", expected_records.size());
            faults++;
        end

        $display("Fed %0d characters in %0d lines (%0d directed characters), %0d records compared.",
                 total, line_count, directed_len, compared);
        $display("Traffic cycled through steady flow, sender gaps, record stalls and both.");
        if (faults == 0)
        begin
            $display("log_timestamp_parser_unit_tb passed");
        end
        else
        begin
            $display("log_timestamp_parser_unit_tb failed");
        end
        $finish;
    end
endmodule

### files.f
+incdir+sv
sv/ltp_pkg.sv
sv/ltp_char_if.sv
sv/ltp_rec_if.sv
sv/ltp_front.sv
sv/ltp_queue.sv
sv/ltp_back.sv
sv/log_timestamp_parser_unit.sv
dv/log_timestamp_parser_unit_tb.sv
